// ----- design/hnd_pkg.sv -----
// Shared constants, types and helpers for the Hamming nearest-digit vote block.
// Used by every module of the block; depends on nothing.
package hnd_pkg;

    // Image and class geometry.
    localparam int IMAGE_BYTES = 98;
    localparam int NUM_CLASSES = 10;

    // Field widths fixed by the interface.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 7;
    localparam int BYTE_W  = 8;
    localparam int LABEL_W = 4;
    localparam int DIST_W  = 10;
    localparam int POP_W   = $clog2(BYTE_W + 1);

    // Queue between the front and the back.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [DIST_W-1:0] LIMIT_RESET = DIST_W'(100);
    localparam logic [DIST_W-1:0] DIST_MAX    = {DIST_W{1'b1}};

    // Request opcodes.
    localparam logic [OP_W-1:0] OP_QUERY   = 2'd0;
    localparam logic [OP_W-1:0] OP_REF     = 2'd1;
    localparam logic [OP_W-1:0] OP_RESTART = 2'd2;

    // One classified request on its way to the back.
    typedef struct packed {
        logic               restart;
        logic [POP_W-1:0]   pop;
        logic [LABEL_W-1:0] label;
        logic               last;
    } hnd_entry_t;

    // One finished result.
    typedef struct packed {
        logic [DIST_W-1:0]  distance;
        logic               new_best;
        logic [LABEL_W-1:0] label_echo;
        logic [DIST_W-1:0]  best_distance;
        logic [LABEL_W-1:0] predicted_digit;
        logic               prediction_valid;
        logic [DIST_W-1:0]  leader_votes;
    } hnd_result_t;

    function automatic logic [POP_W-1:0] popcount8(input logic [BYTE_W-1:0] v);
        logic [POP_W-1:0] n;
        n = '0;
        for (int b = 0; b < BYTE_W; b++)
        begin
            n = n + POP_W'(v[b]);
        end
        return n;
    endfunction

endpackage

// ----- design/hnd_front.sv -----
// Front of the vote block: accepts requests, holds the query image memory and
// turns each reference byte into a bit-difference count. Depends on hnd_pkg.
module hnd_front import hnd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [OP_W-1:0]     opcode,
    input  logic [IDX_W-1:0]    byte_index,
    input  logic [BYTE_W-1:0]   data_byte,
    input  logic [LABEL_W-1:0]  ref_label,
    input  logic                last_byte,
    output logic                push_valid,
    input  logic                push_ready,
    output hnd_entry_t          push_entry
);

    logic [BYTE_W-1:0] query_mem [IMAGE_BYTES];

    logic               st_valid_reg;
    logic               st_valid_next;
    logic               st_restart_reg;
    logic               st_hit_reg;
    logic [BYTE_W-1:0]  st_query_reg;
    logic [BYTE_W-1:0]  st_data_reg;
    logic [LABEL_W-1:0] st_label_reg;
    logic               st_last_reg;

    logic accept;
    logic idx_ok;
    logic forward;

    assign in_ready = !st_valid_reg || push_ready;
    assign accept   = in_valid && in_ready;
    assign idx_ok   = byte_index < IDX_W'(IMAGE_BYTES);

    // Query loads finish here; only reference bytes and restarts go on.
    always_comb
    begin
        unique case (opcode)
            OP_REF, OP_RESTART: forward = 1'b1;
            default:            forward = 1'b0;
        endcase
    end

    always_comb
    begin
        st_valid_next = st_valid_reg;
        if (accept)
        begin
            st_valid_next = forward;
        end
        else if (push_ready)
        begin
            st_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_valid_reg <= 1'b0;
        end
        else
        begin
            st_valid_reg <= st_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            if (opcode == OP_QUERY && idx_ok)
            begin
                query_mem[byte_index] <= data_byte;
            end
            if (opcode == OP_REF && idx_ok)
            begin
                st_query_reg <= query_mem[byte_index];
            end
            st_restart_reg <= (opcode == OP_RESTART);
            st_hit_reg     <= idx_ok;
            st_data_reg    <= data_byte;
            st_label_reg   <= ref_label;
            st_last_reg    <= last_byte;
        end
    end

    assign push_valid         = st_valid_reg;
    assign push_entry.restart = st_restart_reg;
    assign push_entry.pop     = st_hit_reg ? popcount8(st_query_reg ^ st_data_reg) : '0;
    assign push_entry.label   = st_label_reg;
    assign push_entry.last    = st_last_reg;

endmodule

// ----- design/hnd_queue.sv -----
// Short request queue that decouples the front from the back of the vote block.
// Depends on hnd_pkg for the entry type and depth.
module hnd_queue import hnd_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push_valid,
    output logic       push_ready,
    input  hnd_entry_t push_entry,
    output logic       pop_valid,
    input  logic       pop_ready,
    output hnd_entry_t pop_entry
);

    hnd_entry_t slot_reg [QDEPTH];

    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- design/hnd_back.sv -----
// Back of the vote block: accumulates the distance, tracks the best match,
// counts votes and keeps the leading digit, then registers each result.
// Depends on hnd_pkg.
module hnd_back import hnd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              pop_valid,
    output logic              pop_ready,
    input  hnd_entry_t        pop_entry,
    input  logic [DIST_W-1:0] limit,
    output logic              out_valid,
    input  logic              out_ready,
    output hnd_result_t       result
);

    localparam int CLS_W = $clog2(NUM_CLASSES);

    logic [DIST_W-1:0]  vote_reg [NUM_CLASSES];
    logic [DIST_W-1:0]  run_reg;
    logic [DIST_W-1:0]  run_next;
    logic [DIST_W-1:0]  best_reg;
    logic [DIST_W-1:0]  best_next;
    logic [CLS_W-1:0]   lead_dig_reg;
    logic [CLS_W-1:0]   lead_dig_next;
    logic [DIST_W-1:0]  lead_cnt_reg;
    logic [DIST_W-1:0]  lead_cnt_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    hnd_result_t        result_reg;

    logic               fire;
    logic               finish;
    logic [DIST_W:0]    sum;
    logic [DIST_W-1:0]  cur_dist;
    logic               beat;
    logic               label_ok;
    logic [CLS_W-1:0]   cls;
    logic [DIST_W-1:0]  vote_cur;
    logic [DIST_W-1:0]  vote_inc;
    logic               cast;
    logic               take_lead;

    // Only a finishing reference byte needs room in the output register.
    assign finish    = !pop_entry.restart && pop_entry.last;
    assign pop_ready = !finish || !out_valid_reg || out_ready;
    assign fire      = pop_valid && pop_ready;

    assign sum      = {1'b0, run_reg} + (DIST_W + 1)'(pop_entry.pop);
    assign cur_dist = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    assign beat     = cur_dist < best_reg;

    assign label_ok = pop_entry.label < LABEL_W'(NUM_CLASSES);
    assign cls      = pop_entry.label[CLS_W-1:0];
    assign vote_cur = label_ok ? vote_reg[cls] : '0;
    assign vote_inc = (vote_cur == DIST_MAX) ? vote_cur : vote_cur + 1'b1;
    assign cast     = fire && finish && beat && label_ok;

    // Only one count moves, and by one, so the leader changes only towards it;
    // on a tie the lower digit keeps or takes the lead.
    assign take_lead = (vote_inc > lead_cnt_reg)
                    || (vote_inc == lead_cnt_reg && cls < lead_dig_reg);

    always_comb
    begin
        run_next       = run_reg;
        best_next      = best_reg;
        lead_dig_next  = lead_dig_reg;
        lead_cnt_next  = lead_cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (fire)
        begin
            if (pop_entry.restart)
            begin
                run_next      = '0;
                best_next     = limit;
                lead_dig_next = '0;
                lead_cnt_next = '0;
            end
            else if (pop_entry.last)
            begin
                run_next       = '0;
                out_valid_next = 1'b1;
                if (beat)
                begin
                    best_next = cur_dist;
                end
                if (cast && take_lead)
                begin
                    lead_dig_next = cls;
                    lead_cnt_next = vote_inc;
                end
            end
            else
            begin
                run_next = cur_dist;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg       <= '0;
            best_reg      <= LIMIT_RESET;
            lead_dig_reg  <= '0;
            lead_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_CLASSES; k++)
            begin
                vote_reg[k] <= '0;
            end
        end
        else
        begin
            run_reg       <= run_next;
            best_reg      <= best_next;
            lead_dig_reg  <= lead_dig_next;
            lead_cnt_reg  <= lead_cnt_next;
            out_valid_reg <= out_valid_next;
            if (fire && pop_entry.restart)
            begin
                for (int k = 0; k < NUM_CLASSES; k++)
                begin
                    vote_reg[k] <= '0;
                end
            end
            else if (cast)
            begin
                vote_reg[cls] <= vote_inc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && finish)
        begin
            result_reg.distance         <= cur_dist;
            result_reg.new_best         <= beat;
            result_reg.label_echo       <= pop_entry.label;
            result_reg.best_distance    <= best_next;
            result_reg.predicted_digit  <= LABEL_W'(lead_dig_next);
            result_reg.prediction_valid <= lead_cnt_next != '0;
            result_reg.leader_votes     <= lead_cnt_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign result    = result_reg;

endmodule

// ----- design/hamming_nearest_digit_vote.sv -----
// Hamming nearest-digit vote: a binary-image nearest-neighbour classifier that
// takes one request per clock cycle, every cycle, for as long as results are
// taken. A query load writes the 98-entry query memory; each reference byte reads
// that memory through its registered read port and adds the count of differing
// bits to the running distance, and the final byte of a reference gives one
// result, registered in turn by the front stage, the queue and the output register.
// A four-entry queue between the front and the back absorbs short output stalls.
// The limit register is read only on a restart request.
// Depends on hnd_pkg, hnd_front, hnd_queue and hnd_back.
module hamming_nearest_digit_vote import hnd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [OP_W-1:0]    opcode,
    input  logic [IDX_W-1:0]   byte_index,
    input  logic [BYTE_W-1:0]  data_byte,
    input  logic [LABEL_W-1:0] ref_label,
    input  logic               last_byte,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [DIST_W-1:0]  initial_limit,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DIST_W-1:0]  distance,
    output logic               new_best,
    output logic [LABEL_W-1:0] label_echo,
    output logic [DIST_W-1:0]  best_distance,
    output logic [LABEL_W-1:0] predicted_digit,
    output logic               prediction_valid,
    output logic [DIST_W-1:0]  leader_votes
);

    logic [DIST_W-1:0] limit_reg;

    logic        push_valid;
    logic        push_ready;
    hnd_entry_t  push_entry;
    logic        pop_valid;
    logic        pop_ready;
    hnd_entry_t  pop_entry;
    hnd_result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            limit_reg <= initial_limit;
        end
    end

    hnd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .opcode     (opcode),
        .byte_index (byte_index),
        .data_byte  (data_byte),
        .ref_label  (ref_label),
        .last_byte  (last_byte),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry)
    );

    hnd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    hnd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_entry (pop_entry),
        .limit     (limit_reg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .result    (result)
    );

    assign distance         = result.distance;
    assign new_best         = result.new_best;
    assign label_echo       = result.label_echo;
    assign best_distance    = result.best_distance;
    assign predicted_digit  = result.predicted_digit;
    assign prediction_valid = result.prediction_valid;
    assign leader_votes     = result.leader_votes;

endmodule
